### rtl/ltc_pkg.sv
// Shared types and constants for the loop trip count pipeline.
// Used by every module in rtl; depends on nothing.
package ltc_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned InTdataW = 208;
  localparam int unsigned OutTdataW = 72;

  localparam logic [1:0] ModeSigned = 2'b01;
  localparam logic [1:0] ModeIncl = 2'b10;

  typedef struct packed {
    logic              valid;
    logic              early;
    logic              early_known;
    logic [DataW-1:0]  div;
    logic [DataW-1:0]  rem1;
    logic [DataW-1:0]  rem2;
    logic [DataW-1:0]  nq1;
    logic [DataW-1:0]  nq2;
  } div_stage_t;

endpackage

### rtl/ltc_prep.sv
// Input stage: mask and sign-flip operands, classify early results, form dividends.
// Depends on ltc_pkg.
module ltc_prep (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [1:0]                 bound_mode_i,
  input  logic [6:0]                 width_bits_i,
  input  logic [63:0]                start_value_i,
  input  logic [63:0]                limit_value_i,
  input  logic [63:0]                step_value_i,
  output ltc_pkg::div_stage_t        stage_o
);
  import ltc_pkg::*;

  logic [6:0]       wc;
  logic [DataW-1:0] mask, flip, lo, hi, inc;
  logic             incl, past, unk;
  div_stage_t       stage_d, stage_q;

  always_comb begin
    wc = width_bits_i;
    if (wc == 7'd0) wc = 7'd1;
    if (wc > 7'd64) wc = 7'd64;
    incl = (bound_mode_i & ModeIncl) != 2'b00;
    mask = {DataW{1'b1}} >> (7'd64 - wc);
    flip = ((bound_mode_i & ModeSigned) != 2'b00) ? (64'd1 << (wc - 7'd1)) : 64'd0;
    lo   = (start_value_i & mask) ^ flip;
    hi   = (limit_value_i & mask) ^ flip;
    inc  = step_value_i & mask;
    past = (lo > hi) || ((lo == hi) && !incl);
    unk  = (inc == 64'd0) || (incl && (hi == mask));
    stage_d.valid       = valid_i;
    stage_d.early       = past || unk;
    stage_d.early_known = past;
    stage_d.rem1        = '0;
    stage_d.rem2        = '0;
    if (past || unk) begin
      stage_d.div = 64'd1;
      stage_d.nq1 = '0;
      stage_d.nq2 = '0;
    end else begin
      stage_d.div = inc;
      stage_d.nq1 = incl ? (hi - lo) : (hi - lo - 64'd1);
      stage_d.nq2 = mask - lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;
endmodule

### rtl/ltc_div_stage.sv
// One restoring-division step for both dividends against the shared divisor.
// Depends on ltc_pkg.
module ltc_div_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  ltc_pkg::div_stage_t stage_i,
  output ltc_pkg::div_stage_t stage_o
);
  import ltc_pkg::*;

  logic [DataW:0] sh1, sh2, df1, df2;
  logic           ge1, ge2;
  div_stage_t     stage_d, stage_q;

  always_comb begin
    sh1 = {stage_i.rem1, stage_i.nq1[DataW-1]};
    sh2 = {stage_i.rem2, stage_i.nq2[DataW-1]};
    df1 = sh1 - {1'b0, stage_i.div};
    df2 = sh2 - {1'b0, stage_i.div};
    ge1 = sh1 >= {1'b0, stage_i.div};
    ge2 = sh2 >= {1'b0, stage_i.div};
    stage_d      = stage_i;
    stage_d.rem1 = ge1 ? df1[DataW-1:0] : sh1[DataW-1:0];
    stage_d.rem2 = ge2 ? df2[DataW-1:0] : sh2[DataW-1:0];
    stage_d.nq1  = {stage_i.nq1[DataW-2:0], ge1};
    stage_d.nq2  = {stage_i.nq2[DataW-2:0], ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;
endmodule

### rtl/ltc_final.sv
// Output stage: wrap check on the two quotients and the result register.
// Depends on ltc_pkg.
module ltc_final (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  ltc_pkg::div_stage_t stage_i,
  output logic                valid_o,
  output logic                count_known_o,
  output logic [63:0]         iter_count_o
);
  import ltc_pkg::*;

  logic             valid_q, known_d, known_q;
  logic [DataW-1:0] count_d, count_q;

  always_comb begin
    if (stage_i.early) begin
      known_d = stage_i.early_known;
      count_d = '0;
    end else begin
      known_d = stage_i.nq1 < stage_i.nq2;
      count_d = known_d ? (stage_i.nq1 + 64'd1) : 64'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      known_q <= known_d;
      count_q <= count_d;
    end
  end

  assign valid_o       = valid_q;
  assign count_known_o = known_q;
  assign iter_count_o  = count_q;
endmodule

### rtl/loop_trip_count_top.sv
// Loop trip count unit, top level: prep stage, 64 division steps, output stage.
// Depends on ltc_pkg, ltc_prep, ltc_div_stage and ltc_final.
// One loop description is taken per cycle while the output side does not stall, and its
// result passes through one prep register, 64 division stages with one quotient bit
// each, and the output register.
// The whole pipeline advances whenever the output register is empty or being
// transferred, so a stall on the output side holds every stage in place.
module loop_trip_count_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // bound_mode[1:0], width_bits[8:2], start_value[72:9], limit_value[136:73],
  // step_value[200:137], zero fill above
  input  logic [ltc_pkg::InTdataW-1:0]  s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // count_known[0], iter_count[64:1], zero fill above
  output logic [ltc_pkg::OutTdataW-1:0] m_axis_tdata_o
);
  import ltc_pkg::*;

  logic             adv;
  logic             known;
  logic [DataW-1:0] count;
  div_stage_t       stg [0:DataW];

  assign adv = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  ltc_prep u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .valid_i       (s_axis_tvalid_i),
    .bound_mode_i  (s_axis_tdata_i[1:0]),
    .width_bits_i  (s_axis_tdata_i[8:2]),
    .start_value_i (s_axis_tdata_i[72:9]),
    .limit_value_i (s_axis_tdata_i[136:73]),
    .step_value_i  (s_axis_tdata_i[200:137]),
    .stage_o       (stg[0])
  );

  for (genvar i = 0; i < DataW; i++) begin : g_div
    ltc_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .stage_i (stg[i]),
      .stage_o (stg[i+1])
    );
  end

  ltc_final u_final (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .stage_i       (stg[DataW]),
    .valid_o       (m_axis_tvalid_o),
    .count_known_o (known),
    .iter_count_o  (count)
  );

  assign m_axis_tdata_o = {7'd0, count, known};

  a_unknown_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !known |-> count == 64'd0)
    else $error("unknown count carries nonzero trip count");

  a_ready_rule : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready out of step with output stage");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |=> $stable(stg[0]))
    else $error("prep stage moved during stall");
endmodule
